// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the feedback generator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is high
`define UAF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication, disabled while reset is high
`define UAF_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/uaf_pkg.sv
// Shared types and constants of the USB audio feedback generator
`default_nettype none

package uaf_pkg;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int RATE_BITS     = 19;

   // Q16.16 one, and nominal = rate * 65536 / 1000 = (rate * 0x10624DD3) >> 22,
   // exact for every 19-bit rate
   localparam int       Q16_ONE         = 65536;
   localparam int       NOM_RECIP_BITS  = 29;
   localparam int       NOM_RECIP_SHIFT = 22;
   localparam logic [NOM_RECIP_BITS-1:0] NOM_RECIP = 29'h1062_4DD3;
   localparam int       NOM_BITS        = RATE_BITS + NOM_RECIP_BITS - NOM_RECIP_SHIFT;

   localparam logic [31:0] WORD3_MASK = 32'h00FF_FFFF;
   localparam logic [2:0]  BYTES_THREE = 3'd3;
   localparam logic [2:0]  BYTES_FOUR  = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      REG_SAMPLE_RATE   = 3'd0,
      REG_TARGET_FILL   = 3'd1,
      REG_MIN_QUIRK     = 3'd2,
      REG_HIGH_SPEED    = 3'd3,
      REG_FS_Q10_14     = 3'd4,
      REG_HS_Q10_14     = 3'd5,
      REG_FS_FOUR_BYTES = 3'd6,
      REG_HS_FOUR_BYTES = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [RATE_BITS-1:0] sample_rate;
      logic                 min_round_quirk;
      logic                 high_speed;
      logic                 fs_q10_14;
      logic                 hs_q10_14;
      logic                 fs_four_bytes;
      logic                 hs_four_bytes;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/core/usb_audio_async_feedback.sv
// Top level of the USB audio asynchronous explicit feedback generator
//
// One req_ word per start-of-frame tick carries the buffer fill and the two
// endpoint status bits. A tick with both streams active and the feedback
// endpoint idle yields one rsp_ word (feedback value and byte count); any
// other tick is taken and dropped without a result.
// A kept tick waits in a two-entry queue; the back end then runs a restoring
// divider, one bit per cycle, for the fill correction, while the nominal rate
// comes from a registered reciprocal multiply. The back end takes the next
// queued tick only once the last word has moved into the output register.
// req_ready stays high while the queue has room, so ticks are taken in
// consecutive cycles; any tick, dropped or kept, waits only while it is full.
// When the sink holds rsp_ready low the word waits in the output register,
// the back end finishes the next word and stalls, and the queue fills.
// Synchronous reset empties the queue, clears rsp_valid and loads the
// register defaults (48 kHz, fill 512, high speed). The csr_ port writes
// and reads the eight settings at byte addresses 4*i; pready is always high.
`default_nettype none
`include "assert_macros.svh"

module usb_audio_async_feedback #(
   parameter int FILL_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [FILL_BITS-1:0]               req_buffer_fill,
   input  wire logic                               req_streams_active,
   input  wire logic                               req_feedback_busy,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [31:0]                             rsp_feedback_word,
   output logic [2:0]                              rsp_byte_count,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [uaf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [uaf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [uaf_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                    csr_pready
);

   import uaf_pkg::*;

   cfg_type              cfg_ff;
   logic [FILL_BITS-1:0] target_fill_ff;
   reg_index_type        csr_index;
   logic                 csr_write;
   logic                 q_valid, q_pop;
   logic [FILL_BITS-1:0] q_fill;
   logic                 q14_sel, four_sel;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_rate     <= RATE_BITS'(48000);
         target_fill_ff         <= FILL_BITS'(512);
         cfg_ff.min_round_quirk <= 1'b0;
         cfg_ff.high_speed      <= 1'b1;
         cfg_ff.fs_q10_14       <= 1'b1;
         cfg_ff.hs_q10_14       <= 1'b0;
         cfg_ff.fs_four_bytes   <= 1'b0;
         cfg_ff.hs_four_bytes   <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SAMPLE_RATE:   cfg_ff.sample_rate     <= csr_pwdata[RATE_BITS-1:0];
            REG_TARGET_FILL:   target_fill_ff         <= csr_pwdata[FILL_BITS-1:0];
            REG_MIN_QUIRK:     cfg_ff.min_round_quirk <= csr_pwdata[0];
            REG_HIGH_SPEED:    cfg_ff.high_speed      <= csr_pwdata[0];
            REG_FS_Q10_14:     cfg_ff.fs_q10_14       <= csr_pwdata[0];
            REG_HS_Q10_14:     cfg_ff.hs_q10_14       <= csr_pwdata[0];
            REG_FS_FOUR_BYTES: cfg_ff.fs_four_bytes   <= csr_pwdata[0];
            REG_HS_FOUR_BYTES: cfg_ff.hs_four_bytes   <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_SAMPLE_RATE:   csr_prdata = CSR_DATA_BITS'(cfg_ff.sample_rate);
         REG_TARGET_FILL:   csr_prdata = CSR_DATA_BITS'(target_fill_ff);
         REG_MIN_QUIRK:     csr_prdata = CSR_DATA_BITS'(cfg_ff.min_round_quirk);
         REG_HIGH_SPEED:    csr_prdata = CSR_DATA_BITS'(cfg_ff.high_speed);
         REG_FS_Q10_14:     csr_prdata = CSR_DATA_BITS'(cfg_ff.fs_q10_14);
         REG_HS_Q10_14:     csr_prdata = CSR_DATA_BITS'(cfg_ff.hs_q10_14);
         REG_FS_FOUR_BYTES: csr_prdata = CSR_DATA_BITS'(cfg_ff.fs_four_bytes);
         REG_HS_FOUR_BYTES: csr_prdata = CSR_DATA_BITS'(cfg_ff.hs_four_bytes);
      endcase
   end

   uaf_front #(.FILL_BITS(FILL_BITS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_buffer_fill    (req_buffer_fill),
      .req_streams_active (req_streams_active),
      .req_feedback_busy  (req_feedback_busy),
      .q_valid            (q_valid),
      .q_fill             (q_fill),
      .q_pop              (q_pop)
   );

   uaf_back #(.FILL_BITS(FILL_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .target_fill       (target_fill_ff),
      .q_valid           (q_valid),
      .q_fill            (q_fill),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_feedback_word (rsp_feedback_word),
      .rsp_byte_count    (rsp_byte_count)
   );

   assign q14_sel  = cfg_ff.high_speed ? cfg_ff.hs_q10_14 : cfg_ff.fs_q10_14;
   assign four_sel = cfg_ff.high_speed ? cfg_ff.hs_four_bytes : cfg_ff.fs_four_bytes;

   `UAF_ASSERT_IMPLY(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "word valid right after reset")
   `UAF_ASSERT_IMPLY(a_three_byte_mask, clock, reset, rsp_valid && (rsp_byte_count == BYTES_THREE), rsp_feedback_word[31:24] == 8'h00, "three-byte word has high byte set")
   `UAF_ASSERT_IMPLY(a_q14_range, clock, reset, rsp_valid && q14_sel, rsp_feedback_word[31:30] == 2'b00, "Q10.14 word out of range")
   `UAF_ASSERT_IMPLY(a_count_matches_speed, clock, reset, rsp_valid, rsp_byte_count == (four_sel ? BYTES_FOUR : BYTES_THREE), "byte count disagrees with speed setting")

endmodule

`default_nettype wire

// File: rtl/core/uaf_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none

module uaf_div #(
   parameter int DW = 32,
   parameter int VW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW:0]   trial;
   logic [VW+1:0] diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      diff    = {1'b0, trial} - {2'b00, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // keep the trial remainder when the subtract borrows
         quo_in = {quo_ff[DW-2:0], ~diff[VW+1]};
         rem_in = diff[VW+1] ? trial[VW-1:0] : diff[VW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = ~busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/core/uaf_front.sv
// Front end: accepts ticks, drops the ones that send nothing, queues the rest
`default_nettype none

module uaf_front #(
   parameter int FILL_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [FILL_BITS-1:0] req_buffer_fill,
   input  wire logic                 req_streams_active,
   input  wire logic                 req_feedback_busy,
   output logic                      q_valid,
   output logic [FILL_BITS-1:0]      q_fill,
   input  wire logic                 q_pop
);

   import uaf_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [FILL_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 push;

   assign req_ready = (count_ff != CW'(QUEUE_DEPTH));
   // only a tick with both streams up and the endpoint idle gets a word
   assign push      = req_valid & req_ready & req_streams_active & ~req_feedback_busy;
   assign q_valid   = (count_ff != '0);
   assign q_fill    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_buffer_fill;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/uaf_back.sv
// Back end: divides, clamps and formats one feedback word, holds it for the sink
`default_nettype none

module uaf_back #(
   parameter int FILL_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  uaf_pkg::cfg_type          cfg,
   input  wire logic [FILL_BITS-1:0] target_fill,
   input  wire logic                 q_valid,
   input  wire logic [FILL_BITS-1:0] q_fill,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [31:0]               rsp_feedback_word,
   output logic [2:0]                rsp_byte_count
);

   import uaf_pkg::*;

   localparam int OW = FILL_BITS + 16;
   localparam int SW = ((OW > NOM_BITS) ? OW : NOM_BITS) + 2;
   localparam int MW = RATE_BITS + NOM_RECIP_BITS;
   localparam logic signed [SW-1:0] ONE_Q = SW'(Q16_ONE);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_CLAMP} state_type;

   state_type            state_ff;
   logic                 neg_ff;
   logic                 zero_ff;
   logic signed [SW-1:0] sum_ff, fmin_ff, fmax_ff;
   logic [NOM_BITS-1:0]  nom_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_word_ff;
   logic [2:0]           rsp_count_ff;

   logic [FILL_BITS:0]   diff;
   logic                 diff_neg;
   logic [FILL_BITS-1:0] mag;
   logic [MW-1:0]        nom_prod;
   logic [OW-1:0]        off_quo;
   logic                 off_done;
   logic signed [SW-1:0] nom_s, off_mag, off_s, fmin_q;
   logic signed [SW-1:0] fb_clamp;
   logic [31:0]          word_in;
   logic                 q14_sel, four_sel, out_free;

   assign q_pop    = (state_ff == ST_IDLE) & q_valid;
   assign diff     = {1'b0, target_fill} - {1'b0, q_fill};
   assign diff_neg = diff[FILL_BITS];
   assign mag      = diff_neg ? FILL_BITS'(-diff) : diff[FILL_BITS-1:0];
   // nominal by reciprocal multiply, registered ahead of the sum
   assign nom_prod = MW'(cfg.sample_rate) * MW'(NOM_RECIP);

   uaf_div #(.DW(OW), .VW(FILL_BITS)) u_div_off (
      .clock    (clock),
      .reset    (reset),
      .start    (q_pop),
      .dividend ({mag, 16'h0000}),
      .divisor  (target_fill),
      .done     (off_done),
      .quotient (off_quo)
   );

   always_comb begin
      nom_s   = {{(SW-NOM_BITS){1'b0}}, nom_ff};
      off_mag = {{(SW-OW){1'b0}}, off_quo};
      // zero target fill gives nominal feedback
      off_s   = zero_ff ? '0 : (neg_ff ? -off_mag : off_mag);
      // quirk floor minimum applies only when the rate is not a whole kilohertz
      if (cfg.min_round_quirk && (nom_s[15:0] != 16'h0000)) begin
         fmin_q = {nom_s[SW-1:16], 16'h0000};
      end else begin
         fmin_q = nom_s - ONE_Q;
      end

      if (sum_ff < fmin_ff) begin
         fb_clamp = fmin_ff;
      end else if (sum_ff > fmax_ff) begin
         fb_clamp = fmax_ff;
      end else begin
         fb_clamp = sum_ff;
      end
      if (fb_clamp < 0) begin
         fb_clamp = '0;
      end

      q14_sel  = cfg.high_speed ? cfg.hs_q10_14 : cfg.fs_q10_14;
      four_sel = cfg.high_speed ? cfg.hs_four_bytes : cfg.fs_four_bytes;
      word_in  = fb_clamp[31:0];
      if (q14_sel) begin
         word_in = word_in >> 2;
      end
      if (!four_sel) begin
         word_in = word_in & WORD3_MASK;
      end
      out_free = ~rsp_valid_ff | rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_CLAMP) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (off_done) begin
                  state_ff <= ST_CLAMP;
               end
            end
            ST_CLAMP: begin
               // hold the word until the output register frees up
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      nom_ff <= nom_prod[MW-1:NOM_RECIP_SHIFT];
      if (q_pop) begin
         neg_ff  <= diff_neg;
         zero_ff <= (target_fill == '0);
      end
      if (state_ff == ST_DIV) begin
         sum_ff  <= nom_s + off_s;
         fmax_ff <= nom_s + ONE_Q;
         fmin_ff <= fmin_q;
      end
      if ((state_ff == ST_CLAMP) && out_free) begin
         rsp_word_ff  <= word_in;
         rsp_count_ff <= four_sel ? BYTES_FOUR : BYTES_THREE;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_feedback_word = rsp_word_ff;
   assign rsp_byte_count    = rsp_count_ff;

endmodule

`default_nettype wire

// File: sim/usb_audio_async_feedback_checker.sv
// Watches the tick, feedback and register ports, predicts each feedback word and compares it
`default_nettype none

module usb_audio_async_feedback_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_ready,
   input  wire logic [15:0]                        req_buffer_fill,
   input  wire logic                               req_streams_active,
   input  wire logic                               req_feedback_busy,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic [31:0]                        rsp_feedback_word,
   input  wire logic [2:0]                         rsp_byte_count,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [uaf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [uaf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  wire logic                               csr_pready,
   output int                                      failures,
   output int                                      words_due,
   output int                                      ticks_taken,
   output int                                      words_checked
);
   import uaf_pkg::*;

   localparam longint FRAMES_PER_SECOND = 1000;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  bytes;
   } feedback_type;

   cfg_type        settings;
   logic [15:0]    fill_target;
   feedback_type   feedback_due[$];
   int             fail_total;
   int             tick_total;
   int             word_total;

   function automatic feedback_type predict_feedback(logic [15:0] fill);
      longint       rate;
      longint       nominal;
      longint       fb_max;
      longint       fb_min;
      longint       offset;
      longint       fb;
      longint       t;
      logic         q14;
      logic         four;
      feedback_type res;
      rate = longint'(settings.sample_rate);
      nominal = (rate * Q16_ONE) / FRAMES_PER_SECOND;
      fb_max = nominal + Q16_ONE;
      fb_min = nominal - Q16_ONE;
      // quirk: whole samples per frame as the floor for fractional rates
      if (settings.min_round_quirk && (rate % FRAMES_PER_SECOND) != 0)
         fb_min = (rate / FRAMES_PER_SECOND) * Q16_ONE;
      offset = 0;
      if (fill_target != 0) begin
         t = longint'(fill_target);
         offset = ((t - longint'(fill)) * Q16_ONE) / t;
      end
      fb = nominal + offset;
      if (fb < fb_min)
         fb = fb_min;
      else if (fb > fb_max)
         fb = fb_max;
      if (fb < 0)
         fb = 0;
      q14 = settings.high_speed ? settings.hs_q10_14 : settings.fs_q10_14;
      four = settings.high_speed ? settings.hs_four_bytes : settings.fs_four_bytes;
      if (q14)
         fb = fb >>> 2;
      res.word = four ? fb[31:0] : (fb[31:0] & WORD3_MASK);
      res.bytes = four ? BYTES_FOUR : BYTES_THREE;
      return res;
   endfunction

   task automatic note_failure(string what, logic [31:0] want, logic [31:0] got);
      fail_total = fail_total + 1;
      if (fail_total <= 10)
         $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      feedback_type seen;
      feedback_type want;
      if (reset) begin
         settings.sample_rate = 19'd48000;
         settings.min_round_quirk = 1'b0;
         settings.high_speed = 1'b1;
         settings.fs_q10_14 = 1'b1;
         settings.hs_q10_14 = 1'b0;
         settings.fs_four_bytes = 1'b0;
         settings.hs_four_bytes = 1'b1;
         fill_target = 16'd512;
         feedback_due.delete();
         fail_total = 0;
         tick_total = 0;
         word_total = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.word = rsp_feedback_word;
            seen.bytes = rsp_byte_count;
            word_total = word_total + 1;
            if (feedback_due.size() == 0) begin
               note_failure("feedback word with none outstanding", '0, seen.word);
            end else begin
               want = feedback_due.pop_front();
               if (seen.word !== want.word)
                  note_failure("feedback_word mismatch", want.word, seen.word);
               if (seen.bytes !== want.bytes)
                  note_failure("byte_count mismatch", 32'(want.bytes), 32'(seen.bytes));
            end
         end
         if (req_valid && req_ready) begin
            tick_total = tick_total + 1;
            // drop ticks with a stream down or the endpoint still busy
            if (req_streams_active && !req_feedback_busy)
               feedback_due.push_back(predict_feedback(req_buffer_fill));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_SAMPLE_RATE:   settings.sample_rate = csr_pwdata[RATE_BITS-1:0];
               REG_TARGET_FILL:   fill_target = csr_pwdata[15:0];
               REG_MIN_QUIRK:     settings.min_round_quirk = csr_pwdata[0];
               REG_HIGH_SPEED:    settings.high_speed = csr_pwdata[0];
               REG_FS_Q10_14:     settings.fs_q10_14 = csr_pwdata[0];
               REG_HS_Q10_14:     settings.hs_q10_14 = csr_pwdata[0];
               REG_FS_FOUR_BYTES: settings.fs_four_bytes = csr_pwdata[0];
               REG_HS_FOUR_BYTES: settings.hs_four_bytes = csr_pwdata[0];
               default: ;
            endcase
         end
      end
      failures <= fail_total;
      words_due <= feedback_due.size();
      ticks_taken <= tick_total;
      words_checked <= word_total;
   end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Top of the feedback generator bench: clock, reset, tick and register stimulus, verdict
`default_nettype none

module testbench;
   import uaf_pkg::*;

   localparam int LATENCY_WAIT = 40;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic [15:0]               req_buffer_fill = '0;
   logic                      req_streams_active = 1'b0;
   logic                      req_feedback_busy = 1'b0;
   logic                      rsp_ready = 1'b0;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata = '0;

   wire logic                      req_ready;
   wire logic                      rsp_valid;
   wire logic [31:0]               rsp_feedback_word;
   wire logic [2:0]                rsp_byte_count;
   wire logic [CSR_DATA_BITS-1:0]  csr_prdata;
   wire logic                      csr_pready;

   int           failures;
   int           words_due;
   int           ticks_taken;
   int           words_checked;
   int           send_idle_pct = 26;
   int           recv_idle_pct = 56;
   int           hold_off_cycles = 0;
   int           settings_used = 1;
   logic [15:0]  cur_target = 16'd512;

   usb_audio_async_feedback #(
      .FILL_BITS(16)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_buffer_fill    (req_buffer_fill),
      .req_streams_active (req_streams_active),
      .req_feedback_busy  (req_feedback_busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_feedback_word  (rsp_feedback_word),
      .rsp_byte_count     (rsp_byte_count),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   usb_audio_async_feedback_checker fb_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_buffer_fill    (req_buffer_fill),
      .req_streams_active (req_streams_active),
      .req_feedback_busy  (req_feedback_busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_feedback_word  (rsp_feedback_word),
      .rsp_byte_count     (rsp_byte_count),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .failures           (failures),
      .words_due          (words_due),
      .ticks_taken        (ticks_taken),
      .words_checked      (words_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // feedback sink: random stalls, or a counted hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // leave the bus in its access phase; the next write or the end of set_config moves it on
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic set_config(int rate, int target, bit quirk, bit hs, bit fsq, bit hsq,
                             bit fs4, bit hs4);
      write_reg(REG_SAMPLE_RATE, 32'(rate));
      write_reg(REG_TARGET_FILL, 32'(target));
      write_reg(REG_MIN_QUIRK, {31'd0, quirk});
      write_reg(REG_HIGH_SPEED, {31'd0, hs});
      write_reg(REG_FS_Q10_14, {31'd0, fsq});
      write_reg(REG_HS_Q10_14, {31'd0, hsq});
      write_reg(REG_FS_FOUR_BYTES, {31'd0, fs4});
      write_reg(REG_HS_FOUR_BYTES, {31'd0, hs4});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_target = 16'(target);
      settings_used = settings_used + 1;
   endtask

   task automatic send_tick(logic [15:0] fill, logic active, logic busy);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap = gap + 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_buffer_fill <= fill;
      req_streams_active <= active;
      req_feedback_busy <= busy;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off until every feedback word is back, then let the back end settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic random_tick(bit keep_all);
      int          lim;
      logic [15:0] fill;
      logic        active;
      logic        busy;
      lim = 2 * int'(cur_target);
      if (lim > 65535)
         lim = 65535;
      // half the fills lie within twice the target, keeping the correction within one sample
      if ($urandom_range(1))
         fill = 16'($urandom_range(lim));
      else
         fill = 16'($urandom_range(65535));
      active = keep_all || ($urandom_range(9) != 0);
      busy = !keep_all && ($urandom_range(9) < 2);
      send_tick(fill, active, busy);
   endtask

   task automatic random_setting();
      int rate;
      int target;
      case ($urandom_range(3))
         0: rate = 1000 * $urandom_range(384, 8);
         1: rate = $urandom_range(384000, 8000);
         2: rate = $urandom_range(1) ? 8000 : 384000;
         default: rate = 11025 << $urandom_range(5);
      endcase
      case ($urandom_range(3))
         0: target = $urandom_range(16, 1);
         1: target = $urandom_range(65535, 1);
         2: target = $urandom_range(4096, 256);
         default: target = $urandom_range(1) ? 1 : 65535;
      endcase
      set_config(rate, target, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: fill extremes, around the target, dropped ticks
      send_tick(16'd0, 1'b1, 1'b0);
      send_tick(16'hFFFF, 1'b1, 1'b0);
      send_tick(16'd512, 1'b1, 1'b0);
      send_tick(16'd511, 1'b1, 1'b0);
      send_tick(16'd1023, 1'b1, 1'b0);
      send_tick(16'd100, 1'b0, 1'b0);
      send_tick(16'd100, 1'b1, 1'b1);
      send_tick(16'd100, 1'b0, 1'b1);
      drain();

      // fractional rate with the rounded-down minimum, full speed Q10.14, three bytes
      set_config(44100, 1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(16'd0, 1'b1, 1'b0);
      send_tick(16'd1, 1'b1, 1'b0);
      send_tick(16'd2, 1'b1, 1'b0);
      send_tick(16'hFFFF, 1'b1, 1'b0);
      drain();

      // top rate, high speed Q16.16 cut to three bytes
      set_config(384000, 65535, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      send_tick(16'd0, 1'b1, 1'b0);
      send_tick(16'hFFFF, 1'b1, 1'b0);
      send_tick(16'd32767, 1'b1, 1'b0);
      drain();

      // zero target fill gives plain nominal
      set_config(500, 0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(16'hFFFF, 1'b1, 1'b0);
      send_tick(16'd0, 1'b1, 1'b0);
      drain();

      // sub-kilohertz rate drives the clamp below zero: saturate at zero
      set_config(500, 1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
      send_tick(16'hFFFF, 1'b1, 1'b0);
      send_tick(16'd0, 1'b1, 1'b0);
      drain();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int phase = 0; phase < 5; phase++) begin
            random_setting();
            // long sink stall with the source flat out, so the queue backs up
            if (mode == 2 && phase == 0)
               hold_off_cycles = 400;
            for (int n = 0; n < 30; n++)
               random_tick(mode == 2 && phase == 0);
            drain();
         end
      end

      $display("Covered %0d ticks and %0d feedback words over %0d register settings,",
               ticks_taken, words_checked, settings_used);
      $display("with source and sink stalls mixed, none, and one long sink hold-off.");
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/uaf_pkg.sv
rtl/core/uaf_div.sv
rtl/core/uaf_front.sv
rtl/core/uaf_back.sv
rtl/core/usb_audio_async_feedback.sv
sim/usb_audio_async_feedback_checker.sv
sim/testbench.sv
